FILE: hw/rtl/i8dq_pkg.sv
package i8dq_pkg;

  // output lanes carried by one result word
  localparam int unsigned NOUT = 8;

  localparam logic        CMD_LOAD = 1'b0;
  localparam logic        CMD_DATA = 1'b1;

  localparam logic        CFG_USE_ZP = 1'b0;
  localparam logic        CFG_ACTIVE = 1'b1;

  localparam logic [7:0]  ZP_MID     = 8'd128;
  localparam logic [15:0] FP16_QNAN  = 16'h7E00;
  localparam logic [15:0] FP16_QBIT  = 16'h0200;
  localparam logic [15:0] FP16_SIGN  = 16'h8000;
  localparam logic [15:0] FP16_INF   = 16'h7C00;

  typedef logic [15:0] fp16_t;

  typedef struct packed {
    logic adv;  // pipeline advances this cycle
    logic vld;  // last lane stage holds a data word
  } pipe_ctl_t;

  function automatic logic fp16_is_nan(fp16_t b);
    return (b[14:10] == 5'h1F) && (b[9:0] != 10'd0);
  endfunction

  function automatic logic fp16_is_inf(fp16_t b);
    return b[14:0] == FP16_INF[14:0];
  endfunction

  function automatic logic fp16_is_snan(fp16_t b);
    return fp16_is_nan(b) && !b[9];
  endfunction

endpackage

FILE: hw/rtl/i8dq_lane.sv
// one lane: fused round16(q*sc + off), four register stages
module i8dq_lane (
  input  logic                clk,
  input  logic                en,
  input  logic [7:0]          q,
  input  i8dq_pkg::fp16_t     sc,
  input  i8dq_pkg::fp16_t     off,
  output i8dq_pkg::fp16_t     res
);

  localparam int MW = 49;

  // stage 1 comb
  logic            sc_nan, sc_inf, sc_snan, of_nan, of_inf, of_snan;
  logic            spec_c;
  i8dq_pkg::fp16_t spec_v_c;
  logic [10:0]     sig_s, sig_o;
  logic [4:0]      es_c, eo_c;

  always_comb begin
    sc_nan  = i8dq_pkg::fp16_is_nan(sc);
    sc_inf  = i8dq_pkg::fp16_is_inf(sc);
    sc_snan = i8dq_pkg::fp16_is_snan(sc);
    of_nan  = i8dq_pkg::fp16_is_nan(off);
    of_inf  = i8dq_pkg::fp16_is_inf(off);
    of_snan = i8dq_pkg::fp16_is_snan(off);
    spec_c   = 1'b1;
    spec_v_c = '0;
    if (sc_inf && q == 8'd0 && of_nan && !of_snan) begin
      spec_v_c = i8dq_pkg::FP16_QNAN;
    end else if (of_snan) begin
      spec_v_c = off | i8dq_pkg::FP16_QBIT;
    end else if (sc_snan) begin
      spec_v_c = sc | i8dq_pkg::FP16_QBIT;
    end else if (of_nan) begin
      spec_v_c = off;
    end else if (sc_nan) begin
      spec_v_c = sc;
    end else if (sc_inf) begin
      spec_v_c = (q == 8'd0 || (of_inf && off[15] != sc[15])) ? i8dq_pkg::FP16_QNAN : sc;
    end else if (of_inf) begin
      spec_v_c = off;
    end else begin
      spec_c = 1'b0;
    end
    sig_s = (sc[14:10] == 5'd0) ? {1'b0, sc[9:0]} : {1'b1, sc[9:0]};
    sig_o = (off[14:10] == 5'd0) ? {1'b0, off[9:0]} : {1'b1, off[9:0]};
    es_c  = (sc[14:10] == 5'd0) ? 5'd0 : sc[14:10] - 5'd1;
    eo_c  = (off[14:10] == 5'd0) ? 5'd0 : off[14:10] - 5'd1;
  end

  // stage 1 regs
  logic [18:0]     p_r;
  logic [4:0]      es_r, eo_r;
  logic [10:0]     sigo_r;
  logic            ss_r, so_r, sp1_r;
  i8dq_pkg::fp16_t spv1_r;

  always_ff @(posedge clk) begin
    if (en) begin
      p_r    <= 19'(sig_s) * 19'(q);
      es_r   <= es_c;
      eo_r   <= eo_c;
      sigo_r <= sig_o;
      ss_r   <= sc[15];
      so_r   <= off[15];
      sp1_r  <= spec_c;
      spv1_r <= spec_v_c;
    end
  end

  // stage 2: align, signed add as magnitude
  logic [MW-1:0] pm, am, mag_c;
  logic          neg_c;

  always_comb begin
    pm = MW'(p_r) << es_r;
    am = MW'(sigo_r) << eo_r;
    if (ss_r == so_r) begin
      mag_c = pm + am;
      neg_c = ss_r;
    end else if (pm > am) begin
      mag_c = pm - am;
      neg_c = ss_r;
    end else if (am > pm) begin
      mag_c = am - pm;
      neg_c = so_r;
    end else begin
      mag_c = '0;
      neg_c = 1'b0;   // exact cancel gives +0
    end
  end

  logic [MW-1:0]   mag2_r;
  logic            neg2_r, sp2_r;
  i8dq_pkg::fp16_t spv2_r;

  always_ff @(posedge clk) begin
    if (en) begin
      mag2_r <= mag_c;
      neg2_r <= neg_c;
      sp2_r  <= sp1_r;
      spv2_r <= spv1_r;
    end
  end

  // stage 3: leading one search
  logic [5:0] sh_c;

  always_comb begin
    sh_c = '0;
    for (int k = 11; k < MW; k++) begin
      if (mag2_r[k]) sh_c = 6'(k - 10);
    end
  end

  logic [MW-1:0]   mag3_r;
  logic [5:0]      sh3_r;
  logic            neg3_r, sp3_r;
  i8dq_pkg::fp16_t spv3_r;

  always_ff @(posedge clk) begin
    if (en) begin
      mag3_r <= mag2_r;
      sh3_r  <= sh_c;
      neg3_r <= neg2_r;
      sp3_r  <= sp2_r;
      spv3_r <= spv2_r;
    end
  end

  // stage 4: shift and round to nearest even
  logic [MW-1:0]   shd, lowmask;
  logic [11:0]     sig_r12;
  logic [10:0]     sig;
  logic [6:0]      ex;
  logic            rbit, stk;
  logic [16:0]     bits;
  i8dq_pkg::fp16_t res_c;

  always_comb begin
    shd     = mag3_r >> sh3_r;
    lowmask = '0;
    rbit    = 1'b0;
    stk     = 1'b0;
    sig     = shd[10:0];
    ex      = 7'(sh3_r);
    sig_r12 = {1'b0, sig};
    bits    = '0;
    if (sh3_r == 6'd0) begin
      res_c = {neg3_r, 4'd0, mag3_r[10:0]};
    end else begin
      lowmask = (MW'(1) << (sh3_r - 6'd1)) - MW'(1);
      rbit    = mag3_r[sh3_r - 6'd1];
      stk     = |(mag3_r & lowmask);
      sig_r12 = {1'b0, sig} + 12'(rbit && (stk || sig[0]));
      if (sig_r12[11]) begin
        sig_r12 = 12'd1024;
        ex      = ex + 7'd1;
      end
      bits = (17'(ex) << 10) + 17'(sig_r12);
      if (bits >= 17'(i8dq_pkg::FP16_INF)) bits = 17'(i8dq_pkg::FP16_INF);
      res_c = {neg3_r, bits[14:0]};
    end
    if (sp3_r) res_c = spv3_r;
  end

  always_ff @(posedge clk) begin
    if (en) res <= res_c;
  end

endmodule

FILE: hw/rtl/i8dq_merge.sv
// masks inactive lanes and holds the result word
module i8dq_merge (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  i8dq_pkg::pipe_ctl_t                    ctl,
  input  logic [3:0]                             active_lanes,
  input  i8dq_pkg::fp16_t [i8dq_pkg::NOUT-1:0]   lane_res,
  output logic                                   out_tvalid,
  output logic [16*i8dq_pkg::NOUT-1:0]           out_tdata
);

  logic [16*i8dq_pkg::NOUT-1:0] word_c;

  always_comb begin
    for (int i = 0; i < i8dq_pkg::NOUT; i++) begin
      word_c[16*i +: 16] = (4'(i) < active_lanes) ? lane_res[i] : 16'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid <= 1'b0;
    end else if (ctl.adv) begin
      out_tvalid <= ctl.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.adv && ctl.vld) out_tdata <= word_c;
  end

endmodule

FILE: hw/rtl/int8_block_dequant_fp16.sv
// Data word: after acceptance it passes 3 more lane stages and the output register.
// Throughput: one data word per cycle unless stalled or loading; lanes fully pipelined.
// A load word holds in_tready low while the offset unit computes -round16(scale*z),
// z being zp or 128 per the zero-point select; the next word is accepted after that.
// rst_n (synchronous, active low) clears scales and offsets to zero,
// the zero-point select to 0 and active_lanes to 8.
module int8_block_dequant_fp16 #(
  parameter int LANES = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic          in_tuser,   // command
  input  logic [95:0]   in_tdata,   // column[2:0], scale_bits, zp, q_bytes, pad
  output logic          out_tvalid,
  input  logic          out_tready,
  output logic [127:0]  out_tdata,  // lanes_low[63:0], lanes_high[127:64]
  input  logic          cfg_we,
  input  logic          cfg_idx,
  input  logic [3:0]    cfg_data
);

  localparam int LD = 4;   // lane stage count

  // word fields
  logic [2:0]            in_col;
  i8dq_pkg::fp16_t       in_scale;
  logic [7:0]            in_zp;
  logic [63:0]           in_q;

  assign in_col   = in_tdata[2:0];
  assign in_scale = in_tdata[18:3];
  assign in_zp    = in_tdata[26:19];
  assign in_q     = in_tdata[90:27];

  // config
  logic       use_zp_r;
  logic [3:0] active_lanes_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      use_zp_r       <= 1'b0;
      active_lanes_r <= 4'd8;
    end else if (cfg_we) begin
      case (cfg_idx)
        i8dq_pkg::CFG_USE_ZP: use_zp_r       <= cfg_data[0];
        i8dq_pkg::CFG_ACTIVE: active_lanes_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // handshake; the data lanes stall only when the output word is stuck
  i8dq_pkg::pipe_ctl_t ctl;
  logic                adv, acc, ld_acc, dat_acc, ld_busy;
  logic [LD-1:0]       v_r, ld_v_r;
  logic [2:0]          ld_col_r [LD];

  assign adv       = !out_tvalid || out_tready;
  assign ld_busy   = |ld_v_r;
  assign in_tready = adv && !ld_busy;
  assign acc       = in_tvalid && in_tready;
  assign ld_acc    = acc && (in_tuser == i8dq_pkg::CMD_LOAD);
  assign dat_acc   = acc && (in_tuser == i8dq_pkg::CMD_DATA);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r    <= '0;
      ld_v_r <= '0;
    end else begin
      ld_v_r <= {ld_v_r[LD-2:0], ld_acc};
      if (adv) v_r <= {v_r[LD-2:0], dat_acc};
    end
  end

  always_ff @(posedge clk) begin
    ld_col_r[0] <= in_col;
    for (int k = 1; k < LD; k++) ld_col_r[k] <= ld_col_r[k-1];
  end

  // offset unit: round16(scale*z) with a signed zero addend, then negated
  i8dq_pkg::fp16_t ofs_res;
  logic [7:0]      ld_z;

  assign ld_z = use_zp_r ? in_zp : i8dq_pkg::ZP_MID;

  i8dq_lane u_ofs (
    .clk (clk),
    .en  (1'b1),
    .q   (ld_z),
    .sc  (in_scale),
    .off ({in_scale[15], 15'd0}),
    .res (ofs_res)
  );

  // per-column block parameters
  i8dq_pkg::fp16_t lane_scale_r  [LANES];
  i8dq_pkg::fp16_t lane_offset_r [LANES];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j < LANES; j++) begin
        lane_scale_r[j]  <= '0;
        lane_offset_r[j] <= '0;
      end
    end else begin
      for (int j = 0; j < LANES; j++) begin
        if (ld_acc && 32'(in_col) == j) lane_scale_r[j] <= in_scale;
        if (ld_v_r[LD-1] && 32'(ld_col_r[LD-1]) == j)
          lane_offset_r[j] <= ofs_res ^ i8dq_pkg::FP16_SIGN;
      end
    end
  end

  // data lanes
  i8dq_pkg::fp16_t [i8dq_pkg::NOUT-1:0] lane_res;

  for (genvar i = 0; i < i8dq_pkg::NOUT; i++) begin : g_lane
    if (i < LANES) begin : g_on
      i8dq_lane u_lane (
        .clk (clk),
        .en  (adv),
        .q   (in_q[8*i +: 8]),
        .sc  (lane_scale_r[i]),
        .off (lane_offset_r[i]),
        .res (lane_res[i])
      );
    end else begin : g_off
      assign lane_res[i] = '0;
    end
  end

  assign ctl.adv = adv;
  assign ctl.vld = v_r[LD-1];

  i8dq_merge u_merge (
    .clk          (clk),
    .rst_n        (rst_n),
    .ctl          (ctl),
    .active_lanes (active_lanes_r),
    .lane_res     (lane_res),
    .out_tvalid   (out_tvalid),
    .out_tdata    (out_tdata)
  );

`ifndef SYNTHESIS
  a_ld_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    ld_busy |-> !in_tready) else $error("word taken during offset load");
  a_ld_single: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(ld_v_r)) else $error("overlapping offset loads");
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(v_r[LD-1])) else $error("result without data word");
  a_no_dat_ld: assert property (@(posedge clk) disable iff (!rst_n)
    ld_v_r[0] |-> !v_r[0] || $past(!adv)) else $error("data word beside load");
`endif

endmodule
